### rtl/core/kmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the keypad matrix debouncer.
// ----------------------------------------------------------------------------
package kmd_pkg;

   // matrix geometry
   localparam int ROWS         = 4;
   localparam int COLS         = 5;
   localparam int CONTACT_BITS = 20;

   // field widths
   localparam int ROW_W = 2;
   localparam int COL_W = 3;
   localparam int CNT_W = 8;

   localparam logic [CNT_W-1:0] CNT_MAX          = {CNT_W{1'b1}};
   localparam logic [CNT_W-1:0] THRESHOLD_RESET  = 8'd4;

   typedef logic [ROWS-1:0][COLS-1:0] grid_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2
   } event_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'b001,
      MODE_DEBOUNCING = 3'b010,
      MODE_PRESSED    = 3'b100
   } scan_mode_type;

   // first closed key, row-major
   typedef struct packed {
      logic             found;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } scan_hit_type;

   // result item contents
   typedef struct packed {
      event_kind_type   kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } key_event_type;

endpackage
`default_nettype wire

### rtl/core/kmd_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_scan
// Maps a contact snapshot onto the key grid and finds the first closed key.
// ----------------------------------------------------------------------------
module kmd_scan (
   input  wire logic [kmd_pkg::CONTACT_BITS-1:0] contacts,
   output kmd_pkg::grid_type                     grid,
   output kmd_pkg::scan_hit_type                 hit
);
   import kmd_pkg::*;

   // grid view; positions past the input width read as open
   always_comb begin
      grid = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            if (r * COLS + c < CONTACT_BITS) begin
               grid[r][c] = contacts[r * COLS + c];
            end
         end
      end
   end

   // priority encoder, lowest row then lowest column wins
   always_comb begin
      hit = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         for (int c = COLS - 1; c >= 0; c--) begin
            if (grid[r][c]) begin
               hit.found = 1'b1;
               hit.row   = ROW_W'(r);
               hit.col   = COL_W'(c);
            end
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/kmd_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_track
// Debounce state machine for the single tracked key; produces one event
// per scan tick.
// ----------------------------------------------------------------------------
module kmd_track (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [kmd_pkg::CNT_W-1:0]   threshold,
   input  kmd_pkg::grid_type                grid,
   input  kmd_pkg::scan_hit_type            hit,
   output kmd_pkg::key_event_type           evt
);
   import kmd_pkg::*;

   scan_mode_type    mode_ff,  mode_in;
   logic [ROW_W-1:0] row_ff,   row_in;
   logic [COL_W-1:0] col_ff,   col_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             held_closed;
   logic [CNT_W-1:0] count_inc;

   assign held_closed = grid[row_ff][col_ff];
   assign count_inc   = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;

   // next state and event for this tick
   always_comb begin
      mode_in  = mode_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      count_in = count_ff;
      evt      = '{kind: EV_NONE, row: '0, col: '0};
      unique case (mode_ff)
         MODE_DEBOUNCING: begin
            if (!held_closed) begin
               mode_in  = MODE_IDLE;
               row_in   = '0;
               col_in   = '0;
               count_in = '0;
            end else begin
               count_in = count_inc;
               if (count_inc >= threshold) begin
                  mode_in = MODE_PRESSED;
                  evt     = '{kind: EV_PRESS, row: row_ff, col: col_ff};
               end
            end
         end
         MODE_PRESSED: begin
            if (!held_closed) begin
               evt      = '{kind: EV_RELEASE, row: row_ff, col: col_ff};
               mode_in  = MODE_IDLE;
               row_in   = '0;
               col_in   = '0;
               count_in = '0;
            end
         end
         default: begin
            // idle and any stray code
            if (hit.found) begin
               mode_in  = MODE_DEBOUNCING;
               row_in   = hit.row;
               col_in   = hit.col;
               count_in = '0;
            end
         end
      endcase
   end

   // state update once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         count_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/keypad_matrix_debouncer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_matrix_debouncer_core
// Scans a 4x5 key matrix snapshot per item, debounces one key and reports
// press and release events.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         payload
//  req      in   valid / stall     key_contacts[19:0]
//  rsp      out  valid / stall     event_kind[1:0], event_row[1:0], event_col[2:0]
//  csr      in   valid / ready     data[7:0] = debounce threshold
//
//  One item per cycle sustained while rsp is not stalled (input register, then
//  result register). The debounce state updates as an item moves from the
//  input register to the result register. Synchronous reset clears the
//  stages, the state machine and sets the threshold to 4. A stall on rsp
//  holds the result register and backs up into req_stall in the same cycle.
// ----------------------------------------------------------------------------
module keypad_matrix_debouncer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [kmd_pkg::CONTACT_BITS-1:0]   req_key_contacts,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [1:0]                         rsp_event_kind,
   output      logic [kmd_pkg::ROW_W-1:0]          rsp_event_row,
   output      logic [kmd_pkg::COL_W-1:0]          rsp_event_col,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [kmd_pkg::CNT_W-1:0]          csr_data
);
   import kmd_pkg::*;

   logic                    in_valid_ff;
   logic [CONTACT_BITS-1:0] in_data_ff;
   logic                    out_valid_ff;
   key_event_type           out_evt_ff;
   logic [CNT_W-1:0]        threshold_ff;

   logic          advance;
   logic          out_free;
   grid_type      grid;
   scan_hit_type  hit;
   key_event_type evt;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign csr_ready = 1'b1;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_key_contacts;
      end
   end

   kmd_scan u_scan (
      .contacts (in_data_ff),
      .grid     (grid),
      .hit      (hit)
   );

   kmd_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .threshold (threshold_ff),
      .grid      (grid),
      .hit       (hit),
      .evt       (evt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_evt_ff <= evt;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_evt_ff.kind;
   assign rsp_event_row  = out_evt_ff.row;
   assign rsp_event_col  = out_evt_ff.col;

endmodule
`default_nettype wire

### rtl/core/kmd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmd_checker
// Port-level checks for the keypad matrix debouncer.
// ----------------------------------------------------------------------------
module kmd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_event_kind,
   input wire logic [1:0] rsp_event_row,
   input wire logic [2:0] rsp_event_col
);
   import kmd_pkg::*;

   // reset empties the result stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_event_row) && $stable(rsp_event_col))
      else $error("stalled result changed");

   // only defined event codes leave the block
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind != 2'd3)
      else $error("undefined event kind");

   // a no-event item carries a zero position
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_NONE |-> rsp_event_row == '0
         && rsp_event_col == '0)
      else $error("no-event result with nonzero position");

   // event positions stay inside the matrix
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_NONE |-> rsp_event_col < 3'(COLS))
      else $error("event column outside the matrix");

endmodule

bind keypad_matrix_debouncer_core kmd_checker u_kmd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_kind (rsp_event_kind),
   .rsp_event_row  (rsp_event_row),
   .rsp_event_col  (rsp_event_col)
);
`default_nettype wire
